>>> src/hia_pkg.sv
package hia_pkg;

  localparam int MAX_HANDLES = 64;
  localparam int IDX_W = $clog2(MAX_HANDLES);
  localparam int CNT_W = IDX_W + 1;
  localparam int FUNC_W = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_EXHAUSTED     = 2'd1,
    ST_OUT_OF_BOUNDS = 2'd2,
    ST_DROPPED       = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
  } hia_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } hia_sts_t;

endpackage

>>> src/hia_ctrl.sv
module hia_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  hia_pkg::hia_sts_t sts,
  output hia_pkg::hia_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready    = (state == S_IDLE);
  assign cmd.capture = (state == S_IDLE) && s_tvalid;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.finish  = (state == S_FINISH) && !sts.out_busy;

endmodule

>>> src/hia_dpath.sv
module hia_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  hia_pkg::hia_cmd_t             cmd,
  output hia_pkg::hia_sts_t             sts,
  input  logic [hia_pkg::FUNC_W-1:0]    in_func,
  input  logic [hia_pkg::IDX_W-1:0]     in_index,
  input  logic                          cfg_valid,
  input  logic [hia_pkg::CFG_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hia_pkg::STATUS_W-1:0]  out_status,
  output logic [hia_pkg::IDX_W-1:0]     out_index
);

  logic [hia_pkg::CFG_W-1:0]    handles_in_use;
  logic [hia_pkg::FUNC_W-1:0]   req_func;
  logic [hia_pkg::IDX_W-1:0]    req_index;
  logic [hia_pkg::IDX_W-1:0]    pop_ptr;
  logic [hia_pkg::IDX_W-1:0]    push_ptr;
  logic [hia_pkg::CNT_W-1:0]    recycle_count;
  logic [hia_pkg::CNT_W-1:0]    bump_next;
  logic [hia_pkg::IDX_W-1:0]    store [hia_pkg::MAX_HANDLES];
  logic [hia_pkg::IDX_W-1:0]    rd_data;
  logic [hia_pkg::STATUS_W-1:0] res_status;
  logic [hia_pkg::IDX_W-1:0]    res_index;
  logic                         res_from_mem;

  logic [hia_pkg::CNT_W-1:0]    limit;
  logic [hia_pkg::IDX_W-1:0]    pop_ptr_adv;
  logic [hia_pkg::IDX_W-1:0]    push_ptr_adv;
  logic [hia_pkg::CNT_W-1:0]    pop_inc;
  logic [hia_pkg::CNT_W-1:0]    push_inc;
  logic                         mem_re;
  logic                         mem_we;
  logic                         do_bump;
  logic                         do_clear;
  logic [hia_pkg::STATUS_W-1:0] status_next;
  logic [hia_pkg::IDX_W-1:0]    index_next;

  assign limit = (handles_in_use > hia_pkg::CNT_W'(hia_pkg::MAX_HANDLES)) ?
                 hia_pkg::CNT_W'(hia_pkg::MAX_HANDLES) : handles_in_use;

  // wrap when the advanced pointer reaches the limit
  assign pop_inc      = {1'b0, pop_ptr} + hia_pkg::CNT_W'(1);
  assign push_inc     = {1'b0, push_ptr} + hia_pkg::CNT_W'(1);
  assign pop_ptr_adv  = (pop_inc >= limit) ? '0 : pop_inc[hia_pkg::IDX_W-1:0];
  assign push_ptr_adv = (push_inc >= limit) ? '0 : push_inc[hia_pkg::IDX_W-1:0];

  always_comb begin
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    do_bump     = 1'b0;
    do_clear    = 1'b0;
    status_next = hia_pkg::ST_OK;
    index_next  = '0;
    unique case (hia_pkg::func_t'(req_func))
      hia_pkg::FUNC_ALLOC: begin
        if (recycle_count != '0) begin
          mem_re = 1'b1;
        end else if (bump_next < limit) begin
          do_bump    = 1'b1;
          index_next = bump_next[hia_pkg::IDX_W-1:0];
        end else begin
          status_next = hia_pkg::ST_EXHAUSTED;
        end
      end
      hia_pkg::FUNC_FREE: begin
        if ({1'b0, req_index} >= limit) begin
          status_next = hia_pkg::ST_OUT_OF_BOUNDS;
        end else if (recycle_count >= limit) begin
          status_next = hia_pkg::ST_DROPPED;
        end else begin
          mem_we = 1'b1;
        end
      end
      hia_pkg::FUNC_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) store[push_ptr] <= req_index;
    if (cmd.exec && mem_re) rd_data <= store[pop_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func  <= in_func;
      req_index <= in_index;
    end
    if (cmd.exec) begin
      res_status   <= status_next;
      res_index    <= index_next;
      res_from_mem <= mem_re;
    end
    if (cmd.finish) begin
      out_status <= res_status;
      out_index  <= res_from_mem ? rd_data : res_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      handles_in_use <= hia_pkg::CFG_RESET;
      pop_ptr        <= '0;
      push_ptr       <= '0;
      recycle_count  <= '0;
      bump_next      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) handles_in_use <= cfg_data;
      if (cmd.exec) begin
        if (do_clear) begin
          pop_ptr       <= '0;
          push_ptr      <= '0;
          recycle_count <= '0;
          bump_next     <= '0;
        end else begin
          if (mem_re) begin
            pop_ptr       <= pop_ptr_adv;
            recycle_count <= recycle_count - hia_pkg::CNT_W'(1);
          end
          if (mem_we) begin
            push_ptr      <= push_ptr_adv;
            recycle_count <= recycle_count + hia_pkg::CNT_W'(1);
          end
          if (do_bump) bump_next <= bump_next + hia_pkg::CNT_W'(1);
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    recycle_count <= hia_pkg::CNT_W'(hia_pkg::MAX_HANDLES))
    else $error("recycle count above capacity");

  a_bump_bound: assert property (@(posedge clk) disable iff (rst)
    bump_next <= hia_pkg::CNT_W'(hia_pkg::MAX_HANDLES))
    else $error("bump counter above capacity");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && mem_re |=> recycle_count == $past(recycle_count) - hia_pkg::CNT_W'(1))
    else $error("pop did not decrement recycle count");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != hia_pkg::ST_OK |-> out_index == '0)
    else $error("granted index nonzero on error status");

  a_single_op: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $countones({mem_re, mem_we, do_bump, do_clear}) <= 1)
    else $error("more than one datapath action per request");
`endif

endmodule

>>> src/handle_index_allocator_core.sv
// A result reaches the output register through the request, execute and
// finish registers, later while the previous result is still held.
// A new request is taken only once the previous one has passed the execute
// and finish steps, between which the recycle store read is registered.
// Reset: pointers, counts and the output valid clear, the limit returns to 64;
// the recycle store is not cleared.
module handle_index_allocator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [5:0] free_index, [7:6] zero
  input  logic [1:0] s_tuser,   // [1:0] func
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [5:0] granted_index, [7:6] zero
  output logic [1:0] m_tuser,   // [1:0] status
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data   // handles_in_use
);

  hia_pkg::hia_cmd_t cmd;
  hia_pkg::hia_sts_t sts;
  logic [hia_pkg::IDX_W-1:0] granted_index;

  assign cfg_ready = 1'b1;

  hia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hia_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (s_tuser),
    .in_index   (s_tdata[hia_pkg::IDX_W-1:0]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_index  (granted_index)
  );

  assign m_tdata = {2'b00, granted_index};

endmodule

>>> sim/handle_index_allocator_core_tb.sv
`timescale 1ns / 100ps

module handle_index_allocator_core_tb;
  import hia_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    status_t    st;
    logic [5:0] gi;
  } reply_t;

  typedef struct packed {
    logic       cfg_row;
    logic [6:0] cfg_val;
    func_t      fn;
    logic [5:0] idx;
    logic       typed;
    status_t    st;
    logic [5:0] gi;
  } vec_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;   // [5:0] free_index, [7:6] zero
  logic [1:0] s_tuser = 2'd0;   // [1:0] func
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [5:0] granted_index, [7:6] zero
  logic [1:0] m_tuser;          // [1:0] status
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = 7'd0;

  // allocator state as seen from outside
  logic [6:0]  handle_limit = CFG_RESET;
  logic [5:0]  ring [MAX_HANDLES];
  logic [63:0] ring_written = '0;
  logic [5:0]  rd_ptr = '0;
  logic [5:0]  wr_ptr = '0;
  int          ring_fill = 0;
  int          next_fresh = 0;

  reply_t      expected_replies [$];
  logic [5:0]  live_handles [$];

  int   tx_idle_pct = 11;
  int   rx_idle_pct = 57;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   cycles = 0;
  int   mismatches = 0;
  int   replies_seen = 0;
  int   limit_writes = 0;
  int   status_hits [4] = '{0, 0, 0, 0};

  handle_index_allocator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_replies.size());
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic int eff_limit();
    return (handle_limit > MAX_HANDLES) ? MAX_HANDLES : int'(handle_limit);
  endfunction

  function automatic logic [5:0] next_slot(logic [5:0] p);
    int n;
    n = int'(p) + 1;
    if (n >= eff_limit())
      n = 0;
    return n[5:0];
  endfunction

  function automatic void predict_reply(input func_t f, input logic [5:0] idx,
                                        output status_t st, output logic [5:0] gi);
    int lim;
    lim = eff_limit();
    st = ST_OK;
    gi = '0;
    case (f)
      FUNC_ALLOC: begin
        if (ring_fill > 0) begin
          gi = ring[rd_ptr];
          rd_ptr = next_slot(rd_ptr);
          ring_fill--;
        end else if (next_fresh < lim) begin
          gi = next_fresh[5:0];
          next_fresh++;
        end else begin
          st = ST_EXHAUSTED;
        end
      end
      FUNC_FREE: begin
        if (int'(idx) >= lim) begin
          st = ST_OUT_OF_BOUNDS;
        end else if (ring_fill >= lim) begin
          st = ST_DROPPED;
        end else begin
          ring[wr_ptr] = idx;
          ring_written[wr_ptr] = 1'b1;
          wr_ptr = next_slot(wr_ptr);
          ring_fill++;
        end
      end
      FUNC_CLEAR: begin
        rd_ptr = '0;
        wr_ptr = '0;
        ring_fill = 0;
        next_fresh = 0;
      end
      default: ;
    endcase
  endfunction

  // leaves s_tvalid high after the transfer; the caller lowers it when no item follows
  task automatic send_request(input func_t f, input logic [5:0] idx, input logic typed,
                              input status_t st, input logic [5:0] gi);
    status_t    p_st;
    logic [5:0] p_gi;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {2'b00, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_reply(f, idx, p_st, p_gi);
    if (typed)
      expected_replies.push_back('{st, gi});
    else
      expected_replies.push_back('{p_st, p_gi});
    if (f == FUNC_ALLOC && p_st == ST_OK)
      live_handles.push_back(p_gi);
  endtask

  task automatic drain_replies();
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [6:0] v);
    s_tvalid <= 1'b0;
    drain_replies();
    // empty the ring first if a pop could reach a slot that was never filled
    if (ring_fill != 0 && !(&ring_written)) begin
      send_request(FUNC_CLEAR, 6'd0, 1'b0, ST_OK, 6'd0);
      live_handles.delete();
      s_tvalid <= 1'b0;
      drain_replies();
    end
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    handle_limit = v;
    limit_writes++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: status %0d index %0d", $time,
                 m_tuser, m_tdata[5:0]);
      end else begin
        want = expected_replies.pop_front();
        replies_seen++;
        status_hits[m_tuser]++;
        if (m_tuser !== want.st) begin
          mismatches++;
          $display("%0t: status expected %s actual %0d", $time, want.st.name(), m_tuser);
        end
        if (m_tdata[5:0] !== want.gi) begin
          mismatches++;
          $display("%0t: granted index expected %0d actual %0d", $time, want.gi,
                   m_tdata[5:0]);
        end
      end
    end
  end

  initial begin
    vec_t       dir_vecs [NUM_DIRECTED];
    int         phase_items [NUM_PHASES];
    logic [6:0] lim_val;
    func_t      fn;
    logic [5:0] idx;
    int         burst;
    int         alloc_pct;
    int         r;
    int         pick;

    dir_vecs = '{
      '{1'b1, 7'd64,  FUNC_ALLOC, 6'd0,  1'b0, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_ALLOC, 6'd0,  1'b1, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_ALLOC, 6'd0,  1'b1, ST_OK,            6'd1},
      '{1'b0, 7'd0,   FUNC_FREE,  6'd63, 1'b1, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_FREE,  6'd0,  1'b1, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_ALLOC, 6'd0,  1'b1, ST_OK,            6'd63},
      '{1'b0, 7'd0,   FUNC_ALLOC, 6'd0,  1'b1, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_ALLOC, 6'd0,  1'b0, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_NOP,   6'd63, 1'b1, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_FREE,  6'd45, 1'b0, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_CLEAR, 6'd0,  1'b1, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_ALLOC, 6'd0,  1'b1, ST_OK,            6'd0},
      '{1'b1, 7'd1,   FUNC_ALLOC, 6'd0,  1'b0, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_ALLOC, 6'd0,  1'b1, ST_EXHAUSTED,     6'd0},
      '{1'b0, 7'd0,   FUNC_FREE,  6'd1,  1'b1, ST_OUT_OF_BOUNDS, 6'd0},
      '{1'b0, 7'd0,   FUNC_FREE,  6'd0,  1'b1, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_FREE,  6'd0,  1'b1, ST_DROPPED,       6'd0},
      '{1'b0, 7'd0,   FUNC_ALLOC, 6'd0,  1'b1, ST_OK,            6'd0},
      '{1'b1, 7'd0,   FUNC_ALLOC, 6'd0,  1'b0, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_ALLOC, 6'd0,  1'b1, ST_EXHAUSTED,     6'd0},
      '{1'b0, 7'd0,   FUNC_FREE,  6'd0,  1'b1, ST_OUT_OF_BOUNDS, 6'd0},
      '{1'b1, 7'd127, FUNC_ALLOC, 6'd0,  1'b0, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_FREE,  6'd63, 1'b0, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_ALLOC, 6'd0,  1'b0, ST_OK,            6'd0},
      '{1'b0, 7'd0,   FUNC_CLEAR, 6'd0,  1'b1, ST_OK,            6'd0}
    };
    phase_items = '{400, 300, 300, 150, 300, 50, 300, 200};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (dir_vecs[i].cfg_row)
        write_limit(dir_vecs[i].cfg_val);
      else
        send_request(dir_vecs[i].fn, dir_vecs[i].idx, dir_vecs[i].typed,
                     dir_vecs[i].st, dir_vecs[i].gi);
    end
    live_handles.delete();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // sender-light, then receiver-light, then no random idling, apart from the long receiver hold-off
      tx_idle_pct = (p < 3) ? 11 : (p < 6) ? 57 : 0;
      rx_idle_pct = (p < 3) ? 57 : (p < 6) ? 11 : 0;
      case (p)
        0, 6: lim_val = 7'd64;
        1: lim_val = 7'd4;
        2: lim_val = 7'd127;
        3: lim_val = 7'd1;
        5: lim_val = 7'd0;
        default: lim_val = 7'($urandom_range(2, 63));
      endcase
      write_limit(lim_val);
      if (p == 6)
        hold_req <= 1'b1;
      burst = 2;
      for (int k = 0; k < phase_items[p]; k++) begin
        if (k % 24 == 0)
          burst = $urandom_range(2);
        alloc_pct = (burst == 0) ? 80 : (burst == 1) ? 20 : 48;
        r = $urandom_range(99);
        idx = 6'($urandom_range(63));
        if (r < alloc_pct) begin
          fn = FUNC_ALLOC;
        end else if (r < 95) begin
          fn = FUNC_FREE;
          // mostly hand back a live handle; the rest are stray or repeated indices
          if (live_handles.size() != 0 && $urandom_range(99) < 80) begin
            pick = $urandom_range(live_handles.size() - 1);
            idx = live_handles[pick];
            live_handles.delete(pick);
          end
        end else if (r < 97) begin
          fn = FUNC_CLEAR;
          live_handles.delete();
        end else begin
          fn = FUNC_NOP;
        end
        send_request(fn, idx, 1'b0, ST_OK, 6'd0);
      end
    end

    s_tvalid <= 1'b0;
    drain_replies();
    repeat (10) @(posedge clk);

    $display("%0d results checked over %0d limit settings: ok %0d, exhausted %0d,",
             replies_seen, limit_writes, status_hits[ST_OK], status_hits[ST_EXHAUSTED]);
    $display("out of bounds %0d, dropped %0d; %0d mismatches", status_hits[ST_OUT_OF_BOUNDS],
             status_hits[ST_DROPPED], mismatches);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
